// ===== rtl/core/sliding_window_minimum_core_assert.svh =====
// Assertion macros for the sliding window minimum core.
`ifndef SLIDING_WINDOW_MINIMUM_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MINIMUM_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/swm_pkg.sv =====
// Shared constants and types of the sliding window minimum core.
package swm_pkg;

    // Width of the window length register and its value after reset.
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd1;

    // Controls broadcast from the top level to every cell of the row.
    typedef struct packed {
        logic step;   // an item is accepted this cycle
        logic start;  // the item opens a new stream
        logic drop;   // the front entry leaves the window
    } t_cell_ctrl;

endpackage

// ===== rtl/core/swm_if.sv =====
// Channel interfaces of the sliding window minimum core.

// Sample channel: one input item per handshake.
interface swm_in_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           stream_start;

    modport source (output valid, output sample, output stream_start, input ready);
    modport sink   (input valid, input sample, input stream_start, output ready);
endinterface

// Result channel: one window minimum per handshake.
interface swm_out_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_min;

    modport source (output valid, output window_min, input ready);
    modport sink   (input valid, input window_min, output ready);
endinterface

// Configuration channel: writes the window length register.
interface swm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [swm_pkg::CFG_W-1:0]     window_len;

    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

// ===== rtl/core/swm_cell.sv =====
// One cell of the deque row: holds a single (position, value) entry.
module swm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int POS_W        = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  swm_pkg::t_cell_ctrl            i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [POS_W-1:0]               i_sample_pos,
    input  logic                           i_left_keep,
    input  logic                           i_right_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_value,
    input  logic [POS_W-1:0]               i_right_pos,
    output logic                           o_valid,
    output logic                           o_keep,
    output logic                           o_post_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_post_value,
    output logic [POS_W-1:0]               o_post_pos
);

    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic [POS_W-1:0]               r_pos;
    logic                           n_valid;
    logic signed [SAMPLE_WIDTH-1:0] n_value;
    logic [POS_W-1:0]               n_pos;
    logic                           kill;
    logic                           append;

    // The entry is popped when the stream restarts or the new sample is smaller.
    // Because the row is ordered, popped entries always form a tail.
    assign kill   = i_ctrl.start || (r_valid && (r_value > i_sample));
    assign o_keep = r_valid && !kill;

    // The new sample lands in the first free cell behind the kept entries.
    assign append = !o_keep && i_left_keep;

    // Contents after pop and append, handed to the left neighbor.
    always_comb begin
        if (o_keep) begin
            o_post_valid = 1'b1;
            o_post_value = r_value;
            o_post_pos   = r_pos;
        end else if (append) begin
            o_post_valid = 1'b1;
            o_post_value = i_sample;
            o_post_pos   = i_sample_pos;
        end else begin
            o_post_valid = 1'b0;
            o_post_value = r_value;
            o_post_pos   = r_pos;
        end
    end

    // When the front leaves the window, every cell takes its right neighbor's entry.
    always_comb begin
        if (i_ctrl.drop) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
            n_pos   = i_right_pos;
        end else begin
            n_valid = o_post_valid;
            n_value = o_post_value;
            n_pos   = o_post_pos;
        end
    end

    // Valid flag is control state; the entry payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.step) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_value <= n_value;
            r_pos   <= n_pos;
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== rtl/core/sliding_window_minimum_core.sv =====
// Top level of the sliding window minimum core.
// Streams signed samples and, once window_len samples have arrived, returns the minimum
// of the last window_len samples for every sample; samples before that give no result.
// The candidates for the minimum sit in a row of MAX_WINDOW cells, oldest and smallest
// at the front. Each accepted item is compared against every cell at once, the larger
// tail is popped, the sample is appended, and the front is shifted out when it leaves
// the window, all in the cycle the item is accepted, as the row compare is combinational.
// The result is registered and shows in the cycle after its item; one item is taken per
// cycle unless the result channel stalls. A result waiting in the output register only
// holds off a new item while the result channel is stalled. There is no clearing pass
// after reset. A window length of zero acts as one, and one above MAX_WINDOW acts as
// MAX_WINDOW. The window length should be written only while the core is idle.
module sliding_window_minimum_core #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swm_cfg_if.sink               i_cfg_ch,
    swm_in_if.sink                i_sample_ch,
    swm_out_if.source             o_min_ch
);

    `include "sliding_window_minimum_core_assert.svh"

    // Positions count modulo twice the window depth.
    localparam int POS_W = $clog2(2 * MAX_WINDOW);
    localparam int CMP_W = (POS_W > swm_pkg::CFG_W) ? POS_W : swm_pkg::CFG_W;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(2 * MAX_WINDOW - 1);
    localparam logic [CMP_W-1:0] LEN_MAX  = CMP_W'(MAX_WINDOW);
    localparam logic [CMP_W-1:0] LEN_MIN  = CMP_W'(1);

    logic [swm_pkg::CFG_W-1:0]      r_len;
    logic [POS_W-1:0]               r_pos;
    logic [POS_W-1:0]               r_leave;
    logic                           r_filled;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_value;

    logic                           in_acc;
    logic                           start;
    logic [CMP_W-1:0]               len_ext;
    logic [CMP_W-1:0]               len_eff;
    logic [POS_W-1:0]               cur_pos;
    logic [POS_W-1:0]               cur_leave;
    logic                           cur_filled;
    logic [POS_W-1:0]               n_pos;
    logic [POS_W-1:0]               n_leave;
    logic                           n_filled;
    swm_pkg::t_cell_ctrl            ctrl;

    // Row links; the element past the last cell is an empty entry.
    logic [MAX_WINDOW-1:0]          cell_valid;
    logic [MAX_WINDOW-1:0]          keep;
    logic [MAX_WINDOW:0]            post_valid;
    logic signed [SAMPLE_WIDTH-1:0] post_value [MAX_WINDOW+1];
    logic [POS_W-1:0]               post_pos   [MAX_WINDOW+1];

    // Configuration register; writes are always taken.
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= swm_pkg::WINDOW_LEN_RESET;
        end else if (i_cfg_ch.valid) begin
            r_len <= i_cfg_ch.window_len;
        end
    end

    // Effective window length after clamping.
    assign len_ext = CMP_W'(r_len);
    always_comb begin
        if (len_ext == '0) begin
            len_eff = LEN_MIN;
        end else if (len_ext > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = len_ext;
        end
    end

    // Input handshake: a new item may enter whenever the output register frees up.
    assign i_sample_ch.ready = !r_out_valid || o_min_ch.ready;
    assign in_acc            = i_sample_ch.valid && i_sample_ch.ready;
    assign start             = i_sample_ch.stream_start;

    // Counters as seen by this item, after an optional stream restart.
    assign cur_pos    = start ? '0 : r_pos;
    assign cur_leave  = start ? '0 : r_leave;
    assign cur_filled = start ? 1'b0 : r_filled;

    assign n_pos    = (cur_pos == POS_LAST) ? '0 : cur_pos + POS_W'(1);
    assign n_filled = cur_filled || (CMP_W'(n_pos) >= len_eff);

    // Once the window is full each item yields a result and advances the leaving position.
    always_comb begin
        if (!n_filled) begin
            n_leave = cur_leave;
        end else if (cur_leave == POS_LAST) begin
            n_leave = '0;
        end else begin
            n_leave = cur_leave + POS_W'(1);
        end
    end

    assign ctrl.step  = in_acc;
    assign ctrl.start = start;
    assign ctrl.drop  = n_filled && post_valid[0] && (post_pos[0] == cur_leave);

    // Row of cells, front at index zero.
    assign post_valid[MAX_WINDOW] = 1'b0;
    assign post_value[MAX_WINDOW] = '0;
    assign post_pos[MAX_WINDOW]   = '0;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic left_keep;

        if (g == 0) begin : g_front
            assign left_keep = 1'b1;
        end else begin : g_rest
            assign left_keep = keep[g-1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .POS_W        (POS_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_sample      (i_sample_ch.sample),
            .i_sample_pos  (cur_pos),
            .i_left_keep   (left_keep),
            .i_right_valid (post_valid[g+1]),
            .i_right_value (post_value[g+1]),
            .i_right_pos   (post_pos[g+1]),
            .o_valid       (cell_valid[g]),
            .o_keep        (keep[g]),
            .o_post_valid  (post_valid[g]),
            .o_post_value  (post_value[g]),
            .o_post_pos    (post_pos[g])
        );
    end

    // Stream counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_leave  <= '0;
            r_filled <= 1'b0;
        end else if (in_acc) begin
            r_pos    <= n_pos;
            r_leave  <= n_leave;
            r_filled <= n_filled;
        end
    end

    // Output register: loaded by an item that yields a result, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= n_filled;
        end else if (o_min_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_filled) begin
            r_out_value <= post_value[0];
        end
    end

    assign o_min_ch.valid      = r_out_valid;
    assign o_min_ch.window_min = r_out_value;

    // Occupied cells always form an unbroken run from the front.
    `SWM_ASSERT_NOW(a_cells_packed, 1'b1, ((cell_valid & (cell_valid + 1'b1)) == '0),
        "deque cells are not packed at the front")

    // Before the window fills, no sample has left it.
    `SWM_ASSERT_NOW(a_leave_idle, !r_filled, (r_leave == '0),
        "leaving position moved before the window filled")

    // An accepted item that does not shift the front out leaves the front cell occupied.
    `SWM_ASSERT_NEXT(a_front_filled, (in_acc && !ctrl.drop), cell_valid[0],
        "front cell empty after an accepted item")

    // An item that yields no result leaves the output register empty.
    `SWM_ASSERT_NEXT(a_no_result, (in_acc && !n_filled), !r_out_valid,
        "result produced before the window filled")

endmodule
